[hw/rtl/vsau_pkg.sv]
// Package: shared types, item kind codes and address constants of the scroll address unit.
`default_nettype none

package vsau_pkg;

   localparam int unsigned ADDR_W = 15;

   // Item kind codes
   localparam logic [3:0] KIND_CTRL_WRITE   = 4'd0;
   localparam logic [3:0] KIND_STATUS_READ  = 4'd1;
   localparam logic [3:0] KIND_SCROLL_WRITE = 4'd2;
   localparam logic [3:0] KIND_ADDR_WRITE   = 4'd3;
   localparam logic [3:0] KIND_DATA_READ    = 4'd4;
   localparam logic [3:0] KIND_DATA_WRITE   = 4'd5;
   localparam logic [3:0] KIND_INC_HORI     = 4'd6;
   localparam logic [3:0] KIND_INC_VERT     = 4'd7;
   localparam logic [3:0] KIND_COPY_HORI    = 4'd8;
   localparam logic [3:0] KIND_COPY_VERT    = 4'd9;

   localparam logic [ADDR_W-1:0] PALETTE_LIMIT = 15'h3EFF;
   localparam logic [ADDR_W-1:0] STEP_ONE      = 15'h0001;
   localparam logic [ADDR_W-1:0] STEP_ROW      = 15'h0020;
   localparam logic [ADDR_W-1:0] FINE_Y_STEP   = 15'h1000;
   localparam logic [4:0]        COARSE_LAST   = 5'd31;
   localparam logic [4:0]        COARSE_Y_WRAP = 5'd29;
   localparam logic [2:0]        FINE_Y_LAST   = 3'd7;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] bus_data;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] vram_addr;
      logic [ADDR_W-1:0] access_addr;
      logic              access_valid;
      logic [2:0]        fine_x;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] temp_addr;
      logic [ADDR_W-1:0] cur_addr;
      logic [2:0]        fine_scroll_x;
      logic              second_write;
      logic              step_by_32;
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/vsau_update.sv]
// Combinational next-state and result logic for one item of the scroll address unit.
`default_nettype none

module vsau_update (
   input  wire vsau_pkg::req_type   item,
   input  wire vsau_pkg::state_type cur,
   output vsau_pkg::state_type      nxt,
   output vsau_pkg::rsp_type        result
);

   logic [vsau_pkg::ADDR_W-1:0] v;
   logic [vsau_pkg::ADDR_W-1:0] step;
   logic [4:0]                  coarse_y;

   always_comb begin
      nxt      = cur;
      v        = cur.cur_addr;
      step     = cur.step_by_32 ? vsau_pkg::STEP_ROW : vsau_pkg::STEP_ONE;
      coarse_y = v[9:5];
      result.access_addr  = '0;
      result.access_valid = 1'b0;

      case (item.kind)
         vsau_pkg::KIND_CTRL_WRITE: begin
            nxt.temp_addr[11:10] = item.bus_data[1:0];
            nxt.step_by_32       = item.bus_data[2];
         end
         vsau_pkg::KIND_STATUS_READ: begin
            nxt.second_write = 1'b0;
         end
         vsau_pkg::KIND_SCROLL_WRITE: begin
            if (cur.second_write) begin
               nxt.temp_addr[14:12] = item.bus_data[2:0];
               nxt.temp_addr[9:5]   = item.bus_data[7:3];
            end else begin
               nxt.fine_scroll_x  = item.bus_data[2:0];
               nxt.temp_addr[4:0] = item.bus_data[7:3];
            end
            nxt.second_write = ~cur.second_write;
         end
         vsau_pkg::KIND_ADDR_WRITE: begin
            if (cur.second_write) begin
               nxt.temp_addr[7:0] = item.bus_data;
               v                  = nxt.temp_addr;
            end else begin
               nxt.temp_addr[14]   = 1'b0;
               nxt.temp_addr[13:8] = item.bus_data[5:0];
            end
            nxt.second_write = ~cur.second_write;
         end
         vsau_pkg::KIND_DATA_READ: begin
            result.access_addr = v;
            if (v > vsau_pkg::PALETTE_LIMIT) begin
               result.access_addr[12] = 1'b0;
            end
            result.access_valid = 1'b1;
            v = v + step;
         end
         vsau_pkg::KIND_DATA_WRITE: begin
            result.access_addr  = v;
            result.access_valid = 1'b1;
            v = v + step;
         end
         vsau_pkg::KIND_INC_HORI: begin
            if (v[4:0] == vsau_pkg::COARSE_LAST) begin
               v[4:0] = '0;
               v[10]  = ~v[10];
            end else begin
               v = v + vsau_pkg::STEP_ONE;
            end
         end
         vsau_pkg::KIND_INC_VERT: begin
            if (v[14:12] != vsau_pkg::FINE_Y_LAST) begin
               v = v + vsau_pkg::FINE_Y_STEP;
            end else begin
               v[14:12] = '0;
               if (coarse_y == vsau_pkg::COARSE_Y_WRAP) begin
                  v[9:5] = '0;
                  v[11]  = ~v[11];
               end else if (coarse_y == vsau_pkg::COARSE_LAST) begin
                  v[9:5] = '0;
               end else begin
                  v[9:5] = coarse_y + 5'd1;
               end
            end
         end
         vsau_pkg::KIND_COPY_HORI: begin
            v[10]  = cur.temp_addr[10];
            v[4:0] = cur.temp_addr[4:0];
         end
         vsau_pkg::KIND_COPY_VERT: begin
            v[14:11] = cur.temp_addr[14:11];
            v[9:5]   = cur.temp_addr[9:5];
         end
         default: begin
         end
      endcase

      nxt.cur_addr     = v;
      result.vram_addr = v;
      result.fine_x    = nxt.fine_scroll_x;
   end

endmodule

`default_nettype wire

[hw/rtl/vram_scroll_address_unit_core.sv]
// Top level of the scroll address unit: input register, state registers and result register.
// An accepted item waits in the input register; its result then moves into the result
// register, from which its result transfer completes. Throughput: one item per cycle while
// the receiver does not stall, with the state updated as each item leaves the input stage.
// Reset (synchronous, active high) empties both stages and clears the temporary and current
// addresses, fine X, the write toggle and the step flag.
`default_nettype none

module vram_scroll_address_unit_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire vsau_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output vsau_pkg::rsp_type      rsp_payload
);

   // Input stage. It holds one item; it may take a new transfer whenever it is empty or its
   // item moves into the result stage in the same cycle.
   logic              in_valid_ff, in_valid_in;
   vsau_pkg::req_type in_item_ff,  in_item_in;

   // Result stage. It loads a held input item when it is empty or its result is being taken downstream.
   logic              out_valid_ff, out_valid_in;
   vsau_pkg::rsp_type out_item_ff,  out_item_in;

   // Architectural state, updated exactly when an item leaves the input stage.
   vsau_pkg::state_type state_ff, state_in;

   vsau_pkg::state_type state_nxt;
   vsau_pkg::rsp_type   result;
   logic                out_load;
   logic                in_load;

   vsau_update u_update (
      .item   (in_item_ff),
      .cur    (state_ff),
      .nxt    (state_nxt),
      .result (result)
   );

   // The result stage frees up either because it is empty or because its transfer completes.
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;

      if (out_load) begin
         in_valid_in = 1'b0;
         out_item_in = result;
         state_in    = state_nxt;
      end
      if (in_load) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // A result that reports no data access must carry a zero access address.
   a_access_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.access_valid) |-> (rsp_payload.access_addr == '0))
      else $error("access address nonzero without a data access");

   // An item that leaves the input stage must show up as a valid result next cycle.
   a_out_follows_in: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("result stage did not load");

   // The input side only stalls while the input stage holds an item.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled while empty");

   // The result the unit reports as current address matches the architectural state.
   a_vram_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_payload.vram_addr == state_ff.cur_addr))
      else $error("reported address differs from state");

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the scroll address unit: a directed table, then random traffic checked by a predictor.
`timescale 1ns / 1ps

module tb;

   // Kind codes 10 to 15 are unassigned. The block must leave its state alone for them.
   localparam logic [3:0] KIND_UNUSED_FIRST = 4'd10;
   localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;

   // The slowest correct run is about 1500 transfers. Each one waits on a 59 percent sender
   // gap or receiver stall, on top of the two-stage pipeline. This limit is far beyond that.
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS_PER_PHASE = 363;
   localparam int NUM_PHASES = 4;

   // One row of the directed table. When has_report is set, the typed report is the
   // expectation. Otherwise the predictor supplies it.
   typedef struct packed {
      vsau_pkg::req_type item;
      logic              has_report;
      vsau_pkg::rsp_type report;
   } directed_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   vsau_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   vsau_pkg::rsp_type rsp_payload;

   // Predictor copy of the unit's registers.
   logic [14:0] pending_addr = '0;   // temporary address, filled by register writes
   logic [14:0] video_addr   = '0;   // current address
   logic [2:0]  fine_scroll  = '0;
   logic        second_byte  = 1'b0; // the next scroll or address write is the second one
   logic        row_step     = 1'b0; // data accesses step by 32 instead of 1

   vsau_pkg::rsp_type pending_reports[$];
   directed_row_type  directed_rows[$];

   int cycle_count     = 0;
   int error_count     = 0;
   int items_sent      = 0;
   int sender_idle_pct = 0;
   int stall_pct       = 0;

   vram_scroll_address_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The watchdog. A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** vram_scroll_address_unit_core: FAILED **");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate that the current phase sets. It changes only
   // on the falling edge, so the block sees a settled value at every rising edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Applies one item to the predictor state and returns the report that the block should give.
   function automatic vsau_pkg::rsp_type apply_scroll_item(vsau_pkg::req_type item);
      vsau_pkg::rsp_type report;
      logic [7:0]        d;
      logic [4:0]        coarse_y;
      logic [14:0]       step;
      report = '0;
      d = item.bus_data;
      step = row_step ? vsau_pkg::STEP_ROW : vsau_pkg::STEP_ONE;
      case (item.kind)
         vsau_pkg::KIND_CTRL_WRITE: begin
            pending_addr[11:10] = d[1:0];
            row_step = d[2];
         end
         vsau_pkg::KIND_STATUS_READ: begin
            second_byte = 1'b0;
         end
         vsau_pkg::KIND_SCROLL_WRITE: begin
            // The first byte holds fine and coarse X. The second holds fine and coarse Y.
            if (second_byte) begin
               pending_addr[14:12] = d[2:0];
               pending_addr[9:5] = d[7:3];
            end else begin
               fine_scroll = d[2:0];
               pending_addr[4:0] = d[7:3];
            end
            second_byte = ~second_byte;
         end
         vsau_pkg::KIND_ADDR_WRITE: begin
            // The high byte loses its top two bits and clears bit 14. The low byte completes
            // the address and moves it into the current address.
            if (second_byte) begin
               pending_addr[7:0] = d;
               video_addr = pending_addr;
            end else begin
               pending_addr[14:8] = {1'b0, d[5:0]};
            end
            second_byte = ~second_byte;
         end
         vsau_pkg::KIND_DATA_READ: begin
            // Reads above the pattern and name table space fold the palette mirror down.
            report.access_addr = video_addr;
            if (video_addr > vsau_pkg::PALETTE_LIMIT)
               report.access_addr[12] = 1'b0;
            report.access_valid = 1'b1;
            video_addr = video_addr + step;
         end
         vsau_pkg::KIND_DATA_WRITE: begin
            report.access_addr = video_addr;
            report.access_valid = 1'b1;
            video_addr = video_addr + step;
         end
         vsau_pkg::KIND_INC_HORI: begin
            // Coarse X wraps at the tile row end and switches the horizontal name table.
            if (video_addr[4:0] == vsau_pkg::COARSE_LAST) begin
               video_addr[4:0] = '0;
               video_addr[10] = ~video_addr[10];
            end else begin
               video_addr = video_addr + vsau_pkg::STEP_ONE;
            end
         end
         vsau_pkg::KIND_INC_VERT: begin
            // Fine Y carries into coarse Y. Row 29 wraps and switches the vertical table.
            // Rows 30 and 31 lie in attribute space: 31 wraps to 0 without a switch.
            if (video_addr[14:12] != vsau_pkg::FINE_Y_LAST) begin
               video_addr = video_addr + vsau_pkg::FINE_Y_STEP;
            end else begin
               video_addr[14:12] = '0;
               coarse_y = video_addr[9:5];
               if (coarse_y == vsau_pkg::COARSE_Y_WRAP) begin
                  coarse_y = '0;
                  video_addr[11] = ~video_addr[11];
               end else if (coarse_y == vsau_pkg::COARSE_LAST) begin
                  coarse_y = '0;
               end else begin
                  coarse_y = coarse_y + 5'd1;
               end
               video_addr[9:5] = coarse_y;
            end
         end
         vsau_pkg::KIND_COPY_HORI: begin
            video_addr[10] = pending_addr[10];
            video_addr[4:0] = pending_addr[4:0];
         end
         vsau_pkg::KIND_COPY_VERT: begin
            video_addr[14:11] = pending_addr[14:11];
            video_addr[9:5] = pending_addr[9:5];
         end
         default: begin
         end
      endcase
      report.vram_addr = video_addr;
      report.fine_x = fine_scroll;
      return report;
   endfunction

   // Offers one item to the block and waits for the transfer. The task starts and ends at a
   // falling edge, so valid gets at most one assignment per time step. The expectation is
   // queued at the edge that accepts the item.
   task automatic send_item(input vsau_pkg::req_type item, input logic has_report,
                            input vsau_pkg::rsp_type report);
      vsau_pkg::rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (req_stall);
      predicted = apply_scroll_item(item);
      pending_reports.push_back(has_report ? report : predicted);
      if (item.kind < KIND_UNUSED_FIRST)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic send_kind(input logic [3:0] kind, input logic [7:0] data);
      send_item('{kind: kind, bus_data: data}, 1'b0, '0);
   endtask

   task automatic add_row(input logic [3:0] kind, input logic [7:0] data,
                          input logic has_report, input logic [14:0] vram,
                          input logic [14:0] acc, input logic valid, input logic [2:0] fx);
      directed_row_type row;
      row.item = '{kind: kind, bus_data: data};
      row.has_report = has_report;
      row.report = '{vram_addr: vram, access_addr: acc, access_valid: valid, fine_x: fx};
      directed_rows.push_back(row);
   endtask

   // Random traffic, in three shapes. Single items of any kind, including unused codes.
   // A processor session that sets the address and then streams data accesses. A render
   // stretch that loads the scroll and then walks tiles and rows.
   task automatic send_random_burst();
      int          shape;
      int          count;
      logic [7:0]  data;
      logic [3:0]  kind;
      shape = $urandom_range(99);
      if (shape < 35) begin
         if ($urandom_range(9) == 0)
            kind = 4'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
         else
            kind = 4'($urandom_range(vsau_pkg::KIND_COPY_VERT, vsau_pkg::KIND_CTRL_WRITE));
         send_kind(kind, 8'($urandom_range(255)));
      end else if (shape < 65) begin
         if ($urandom_range(1))
            send_kind(vsau_pkg::KIND_STATUS_READ, 8'($urandom_range(255)));
         if ($urandom_range(2) == 0)
            send_kind(vsau_pkg::KIND_CTRL_WRITE, 8'($urandom_range(255)));
         // Half of the high bytes point at the palette page, where reads are mirrored.
         data = 8'($urandom_range(255));
         if ($urandom_range(1))
            data[5:0] = 6'h3F;
         send_kind(vsau_pkg::KIND_ADDR_WRITE, data);
         send_kind(vsau_pkg::KIND_ADDR_WRITE, 8'($urandom_range(255)));
         count = $urandom_range(6, 1);
         repeat (count) begin
            kind = $urandom_range(1) ? vsau_pkg::KIND_DATA_READ : vsau_pkg::KIND_DATA_WRITE;
            send_kind(kind, 8'($urandom_range(255)));
         end
      end else begin
         if ($urandom_range(3) != 0)
            send_kind(vsau_pkg::KIND_STATUS_READ, 8'($urandom_range(255)));
         send_kind(vsau_pkg::KIND_SCROLL_WRITE, 8'($urandom_range(255)));
         // Favor the last fine row and the bottom coarse rows, where the vertical wrap lives.
         data = 8'($urandom_range(255));
         if ($urandom_range(1))
            data = {5'($urandom_range(31, 27)), 3'($urandom_range(7, 6))};
         send_kind(vsau_pkg::KIND_SCROLL_WRITE, data);
         send_kind(vsau_pkg::KIND_COPY_VERT, 8'($urandom_range(255)));
         send_kind(vsau_pkg::KIND_COPY_HORI, 8'($urandom_range(255)));
         count = $urandom_range(12, 1);
         repeat (count) begin
            case ($urandom_range(5))
               0, 1:    kind = vsau_pkg::KIND_INC_HORI;
               2, 3, 4: kind = vsau_pkg::KIND_INC_VERT;
               default: kind = vsau_pkg::KIND_COPY_HORI;
            endcase
            send_kind(kind, 8'($urandom_range(255)));
         end
      end
   endtask

   // Every result transfer is checked against the oldest expectation, field by field.
   always @(posedge clock) begin
      vsau_pkg::rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("result transfer with no expectation pending: %h", rsp_payload);
            error_count++;
         end else begin
            expected = pending_reports.pop_front();
            if (rsp_payload.vram_addr !== expected.vram_addr) begin
               $error("vram_addr: expected %h, actual %h",
                      expected.vram_addr, rsp_payload.vram_addr);
               error_count++;
            end
            if (rsp_payload.access_addr !== expected.access_addr) begin
               $error("access_addr: expected %h, actual %h",
                      expected.access_addr, rsp_payload.access_addr);
               error_count++;
            end
            if (rsp_payload.access_valid !== expected.access_valid) begin
               $error("access_valid: expected %b, actual %b",
                      expected.access_valid, rsp_payload.access_valid);
               error_count++;
            end
            if (rsp_payload.fine_x !== expected.fine_x) begin
               $error("fine_x: expected %h, actual %h",
                      expected.fine_x, rsp_payload.fine_x);
               error_count++;
            end
         end
      end
   end

   initial begin
      int phase_idle[NUM_PHASES];
      int phase_stall[NUM_PHASES];
      int phase_end;
      phase_idle  = '{0, 59, 0, 20};
      phase_stall = '{0, 0, 59, 20};

      // Directed table. The typed rows can be read off by hand: right after reset, at the
      // extremes of the bus byte, across the palette mirror and across the 15-bit wrap.
      add_row(vsau_pkg::KIND_DATA_READ,    8'h00, 1'b1, 15'h0001, 15'h0000, 1'b1, 3'd0);
      add_row(KIND_UNUSED_LAST,            8'hFF, 1'b1, 15'h0001, 15'h0000, 1'b0, 3'd0);
      add_row(vsau_pkg::KIND_STATUS_READ,  8'hFF, 1'b1, 15'h0001, 15'h0000, 1'b0, 3'd0);
      add_row(vsau_pkg::KIND_CTRL_WRITE,   8'hFF, 1'b1, 15'h0001, 15'h0000, 1'b0, 3'd0);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hFF, 1'b1, 15'h0001, 15'h0000, 1'b0, 3'd7);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hFF, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_ADDR_WRITE,   8'hFF, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_ADDR_WRITE,   8'hFF, 1'b1, 15'h3FFF, 15'h0000, 1'b0, 3'd7);
      // A palette read is mirrored, and the address then steps by a row of 32.
      add_row(vsau_pkg::KIND_DATA_READ,    8'h00, 1'b1, 15'h401F, 15'h2FFF, 1'b1, 3'd7);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hFF, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hFF, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_COPY_VERT,    8'h00, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_COPY_HORI,    8'h00, 1'b0, '0, '0, 1'b0, '0);
      // A write at the top address is reported unmirrored, and the step wraps past 15 bits.
      add_row(vsau_pkg::KIND_DATA_WRITE,   8'h00, 1'b1, 15'h001F, 15'h7FFF, 1'b1, 3'd7);
      add_row(vsau_pkg::KIND_COPY_VERT,    8'h00, 1'b0, '0, '0, 1'b0, '0);
      // The current address now has coarse Y 31 and fine Y 7: the row goes to 0 unswitched.
      add_row(vsau_pkg::KIND_INC_VERT,     8'h00, 1'b1, 15'h081F, 15'h0000, 1'b0, 3'd7);
      add_row(vsau_pkg::KIND_INC_HORI,     8'h00, 1'b1, 15'h0C00, 15'h0000, 1'b0, 3'd7);
      // Coarse Y 29 with fine Y 7 wraps and switches the vertical table.
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'h00, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hEF, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_COPY_VERT,    8'h00, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_INC_VERT,     8'h00, 1'b0, '0, '0, 1'b0, '0);
      // Coarse Y 30 with fine Y 7 moves on to 31.
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'h00, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_SCROLL_WRITE, 8'hF7, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_COPY_VERT,    8'h00, 1'b0, '0, '0, 1'b0, '0);
      add_row(vsau_pkg::KIND_INC_VERT,     8'h00, 1'b0, '0, '0, 1'b0, '0);

      // Reset is held from the start of the run and released at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].has_report,
                   directed_rows[i].report);

      // Random phases: no idling, an idle sender, a stalling receiver, then both at once.
      for (int p = 0; p < NUM_PHASES; p++) begin
         sender_idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         phase_end = items_sent + RANDOM_ITEMS_PER_PHASE;
         while (items_sent < phase_end)
            send_random_burst();
      end
      req_valid <= 1'b0;

      // Drain the pipeline, then give the block a few more cycles to show a stray result.
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("** vram_scroll_address_unit_core: PASSED **");
      else
         $display("** vram_scroll_address_unit_core: FAILED **");
      $finish;
   end

endmodule
